>>> src/urx_pkg.sv
package urx_pkg;

   // Ring buffer geometry
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int AVAIL_W    = 6;
   localparam int CNT_W      = (PTR_W > AVAIL_W) ? PTR_W : AVAIL_W;

   // Receiver timing
   localparam int DELAY_W = 16;
   localparam int DATA_W  = 8;
   localparam int POS_W   = $clog2(DATA_W);

   // Short queues between the parts
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_DELAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DELAY   = 2'd2;

   typedef struct packed {
      logic [DELAY_W-1:0] center_delay;
      logic [DELAY_W-1:0] bit_delay;
      logic [DELAY_W-1:0] stop_delay;
   } cfg_type;

   // One classified tick for the ring buffer
   typedef struct packed {
      logic              pop;
      logic              flush;
      logic              push;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic               read_valid;
      logic [DATA_W-1:0]  read_byte;
      logic               peek_valid;
      logic [DATA_W-1:0]  peek_byte;
      logic [AVAIL_W-1:0] available_count;
      logic               overflow_flag;
   } rsp_type;

   typedef enum logic [3:0] {
      RX_IDLE   = 4'b0001,
      RX_CENTER = 4'b0010,
      RX_BITS   = 4'b0100,
      RX_STOP   = 4'b1000
   } rx_phase_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

>>> src/urx_front.sv
module urx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              rx_level,
   input  logic              pop_request,
   input  logic              flush,
   input  urx_pkg::cfg_type  cfg,
   output urx_pkg::cmd_type  cmd
);

   urx_pkg::rx_phase_type              phase_ff, phase_in;
   logic [urx_pkg::DELAY_W-1:0]        wait_ff, wait_in;
   logic [urx_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [urx_pkg::DATA_W-1:0]         shift_ff, shift_in;
   logic                               push;
   logic                               bits_go;
   logic [urx_pkg::DELAY_W-1:0]        bits_wait;
   logic [urx_pkg::POS_W-1:0]          bits_pos;

   always_comb begin
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      push      = 1'b0;
      bits_go   = 1'b0;
      bits_wait = wait_ff;
      bits_pos  = pos_ff;
      unique case (phase_ff)
         urx_pkg::RX_IDLE: begin
            if (cfg.stop_delay != '0 && !rx_level) begin
               phase_in = urx_pkg::RX_CENTER;
               wait_in  = cfg.center_delay;
               pos_in   = '0;
               shift_in = '0;
            end
         end
         urx_pkg::RX_CENTER: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - urx_pkg::DELAY_W'(1);
            end else begin
               // fall into bit timing in the same tick
               bits_go   = 1'b1;
               bits_wait = cfg.bit_delay;
               bits_pos  = '0;
               phase_in  = urx_pkg::RX_BITS;
               pos_in    = '0;
            end
         end
         urx_pkg::RX_BITS: begin
            bits_go = 1'b1;
         end
         urx_pkg::RX_STOP: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - urx_pkg::DELAY_W'(1);
            end else begin
               push     = 1'b1;
               phase_in = urx_pkg::RX_IDLE;
            end
         end
         default: begin
            phase_in = urx_pkg::RX_IDLE;
         end
      endcase
      if (bits_go) begin
         if (bits_wait != '0) begin
            wait_in = bits_wait - urx_pkg::DELAY_W'(1);
         end else begin
            shift_in[bits_pos] = rx_level;
            if (bits_pos == urx_pkg::POS_W'(urx_pkg::DATA_W - 1)) begin
               phase_in = urx_pkg::RX_STOP;
               wait_in  = cfg.stop_delay;
               pos_in   = '0;
            end else begin
               pos_in  = bits_pos + urx_pkg::POS_W'(1);
               wait_in = cfg.bit_delay;
            end
         end
      end
   end

   always_comb begin
      cmd.pop   = pop_request;
      cmd.flush = flush;
      cmd.push  = push;
      cmd.data  = shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= urx_pkg::RX_IDLE;
         wait_ff  <= '0;
         pos_ff   <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

endmodule

>>> src/urx_cmd_queue.sv
module urx_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  urx_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output urx_pkg::cmd_type  head_cmd
);

   urx_pkg::cmd_type              entry_ff [urx_pkg::QUEUE_DEPTH];
   logic [urx_pkg::Q_PTR_W-1:0]   wr_ff, wr_in;
   logic [urx_pkg::Q_PTR_W-1:0]   rd_ff, rd_in;
   logic [urx_pkg::Q_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == urx_pkg::Q_CNT_W'(urx_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + urx_pkg::Q_PTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + urx_pkg::Q_PTR_W'(1) : rd_ff;
      count_in = count_ff + urx_pkg::Q_CNT_W'(push) - urx_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/urx_back.sv
module urx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  urx_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output urx_pkg::rsp_type  rsp
);

   // Ring buffer
   logic [urx_pkg::DATA_W-1:0]  mem [urx_pkg::FIFO_DEPTH];
   logic [urx_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [urx_pkg::PTR_W-1:0]   tail_ff, tail_in;
   logic                        ovf_ff, ovf_in;

   logic [urx_pkg::PTR_W-1:0]   h0, t0, t_next;
   logic                        o0, rvalid, full, wr_en;
   logic [urx_pkg::PTR_W:0]     diff;
   logic [urx_pkg::PTR_W-1:0]   count;

   // Read stage
   logic                        b_valid_ff;
   logic                        b_rvalid_ff;
   logic                        b_pvalid_ff;
   logic [urx_pkg::PTR_W-1:0]   b_count_ff;
   logic                        b_ovf_ff;
   logic [urx_pkg::DATA_W-1:0]  rd_read_ff;
   logic [urx_pkg::DATA_W-1:0]  rd_peek_ff;
   logic [urx_pkg::CNT_W-1:0]   b_count_wide;
   urx_pkg::rsp_type            b_rsp;

   // Result queue
   urx_pkg::rsp_type             rq_ff [urx_pkg::QUEUE_DEPTH];
   logic [urx_pkg::Q_PTR_W-1:0]  rq_wr_ff, rq_rd_ff;
   logic [urx_pkg::Q_CNT_W-1:0]  rq_count_ff;
   logic                         rq_pop;
   logic [urx_pkg::Q_CNT_W-1:0]  committed;

   // Issue only when the result queue can take everything in flight
   assign committed = rq_count_ff + urx_pkg::Q_CNT_W'(b_valid_ff);
   assign cmd_pop   = cmd_valid && (committed < urx_pkg::Q_CNT_W'(urx_pkg::QUEUE_DEPTH));

   always_comb begin
      h0      = cmd.flush ? '0 : head_ff;
      t0      = cmd.flush ? '0 : tail_ff;
      o0      = cmd.flush ? 1'b0 : ovf_ff;
      rvalid  = cmd.pop && (h0 != t0);
      head_in = rvalid ? urx_pkg::next_ptr(h0) : h0;
      t_next  = urx_pkg::next_ptr(t0);
      full    = (t_next == head_in);
      wr_en   = cmd.push && !full;
      tail_in = wr_en ? t_next : t0;
      ovf_in  = o0 | (cmd.push && full);
      if (tail_in >= head_in) begin
         diff = {1'b0, tail_in} - {1'b0, head_in};
      end else begin
         diff = {1'b0, tail_in} + (urx_pkg::PTR_W + 1)'(urx_pkg::FIFO_DEPTH)
                - {1'b0, head_in};
      end
      count = diff[urx_pkg::PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         ovf_ff     <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= cmd_pop;
         if (cmd_pop) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            ovf_ff  <= ovf_in;
         end
      end
   end

   // Memory write and both registered reads; peek forwards a same-cycle push
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         if (wr_en) begin
            mem[t0] <= cmd.data;
         end
         rd_read_ff <= mem[h0];
         if (wr_en && t0 == head_in) begin
            rd_peek_ff <= cmd.data;
         end else begin
            rd_peek_ff <= mem[head_in];
         end
         b_rvalid_ff <= rvalid;
         b_pvalid_ff <= (head_in != tail_in);
         b_count_ff  <= count;
         b_ovf_ff    <= ovf_in;
      end
   end

   always_comb begin
      b_count_wide          = urx_pkg::CNT_W'(b_count_ff);
      b_rsp.read_valid      = b_rvalid_ff;
      b_rsp.read_byte       = b_rvalid_ff ? rd_read_ff : '0;
      b_rsp.peek_valid      = b_pvalid_ff;
      b_rsp.peek_byte       = b_pvalid_ff ? rd_peek_ff : '0;
      b_rsp.available_count = b_count_wide[urx_pkg::AVAIL_W-1:0];
      b_rsp.overflow_flag   = b_ovf_ff;
   end

   assign rsp_valid = (rq_count_ff != '0);
   assign rsp       = rq_ff[rq_rd_ff];
   assign rq_pop    = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         if (b_valid_ff) begin
            rq_wr_ff <= rq_wr_ff + urx_pkg::Q_PTR_W'(1);
         end
         if (rq_pop) begin
            rq_rd_ff <= rq_rd_ff + urx_pkg::Q_PTR_W'(1);
         end
         rq_count_ff <= rq_count_ff + urx_pkg::Q_CNT_W'(b_valid_ff)
                        - urx_pkg::Q_CNT_W'(rq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         rq_ff[rq_wr_ff] <= b_rsp;
      end
   end

endmodule

>>> src/uart_receiver_with_fifo_top.sv
// 8N1 serial receiver with a receive ring buffer.
// Request channel (req_valid / req_stall): one beat per sampling tick, carrying
// the sampled line level, a pop request and a flush request. Response channel
// (rsp_valid / rsp_stall): exactly one beat per request beat, in order, giving
// the byte popped this tick, the oldest byte left, the fill count and the
// sticky overflow flag. Configuration (csr_valid / csr_ready / csr_index /
// csr_wdata): center delay, bit delay and stop delay at indexes 0, 1, 2;
// csr_ready is always high; write only while the block is idle.
// Throughput: one tick per clock cycle while req_stall is low. An accepted
// request beat reaches its response beat through the command queue, the ring
// buffer update with registered memory read, and the result queue.
// Reset clears the receiver to idle, empties the ring buffer, clears overflow
// and zeroes all delays; a stop delay of zero keeps start detection off, so
// nothing is received until the stop delay is written.
// When the response side stalls, the 4-beat result queue fills, the ring
// buffer stops taking commands, the 4-beat command queue fills and then
// req_stall rises; no tick is lost.
module uart_receiver_with_fifo_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_rx_level,
   input  logic                              req_pop_request,
   input  logic                              req_flush,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_read_valid,
   output logic [urx_pkg::DATA_W-1:0]        rsp_read_byte,
   output logic                              rsp_peek_valid,
   output logic [urx_pkg::DATA_W-1:0]        rsp_peek_byte,
   output logic [urx_pkg::AVAIL_W-1:0]       rsp_available_count,
   output logic                              rsp_overflow_flag,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [urx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [urx_pkg::DELAY_W-1:0]       csr_wdata
);

   urx_pkg::cfg_type  cfg_ff;
   urx_pkg::cmd_type  front_cmd;
   urx_pkg::cmd_type  queue_cmd;
   urx_pkg::rsp_type  rsp;
   logic              req_accept;
   logic              cmd_full;
   logic              cmd_valid;
   logic              cmd_pop;

   // Configuration is always ready; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            urx_pkg::CSR_CENTER_DELAY: cfg_ff.center_delay <= csr_wdata;
            urx_pkg::CSR_BIT_DELAY:    cfg_ff.bit_delay    <= csr_wdata;
            urx_pkg::CSR_STOP_DELAY:   cfg_ff.stop_delay   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Hold the request side only when the command queue is full
   assign req_stall  = cmd_full;
   assign req_accept = req_valid && !req_stall;

   // Front: advance the bit timing and classify each tick
   urx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_level    (req_rx_level),
      .pop_request (req_pop_request),
      .flush       (req_flush),
      .cfg         (cfg_ff),
      .cmd         (front_cmd)
   );

   urx_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_cmd   (front_cmd),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_cmd   (queue_cmd)
   );

   // Back: flush, pop, then push on the ring buffer; build the response beat
   urx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_read_valid      = rsp.read_valid;
   assign rsp_read_byte       = rsp.read_byte;
   assign rsp_peek_valid      = rsp.peek_valid;
   assign rsp_peek_byte       = rsp.peek_byte;
   assign rsp_available_count = rsp.available_count;
   assign rsp_overflow_flag   = rsp.overflow_flag;

endmodule

>>> src/urx_checker.sv
module urx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_read_valid,
   input logic [urx_pkg::DATA_W-1:0]        rsp_read_byte,
   input logic                              rsp_peek_valid,
   input logic [urx_pkg::DATA_W-1:0]        rsp_peek_byte,
   input logic [urx_pkg::AVAIL_W-1:0]       rsp_available_count,
   input logic                              rsp_overflow_flag
);

   // No response beat straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_peek_byte) && $stable(rsp_available_count)
         && $stable(rsp_overflow_flag))
      else $error("stalled response changed");

   // Peek is valid exactly when the fill count is nonzero; an invalid peek byte is zero
   a_peek_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peek_valid == (rsp_available_count != '0))
         && (rsp_peek_valid || rsp_peek_byte == '0))
      else $error("peek and fill count disagree");

   // No popped byte reads as zero
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_byte == '0)
      else $error("read byte without a pop");

endmodule

bind uart_receiver_with_fifo_top urx_checker u_urx_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_read_valid      (rsp_read_valid),
   .rsp_read_byte       (rsp_read_byte),
   .rsp_peek_valid      (rsp_peek_valid),
   .rsp_peek_byte       (rsp_peek_byte),
   .rsp_available_count (rsp_available_count),
   .rsp_overflow_flag   (rsp_overflow_flag)
);
